[sv/mailbox_semaphore_mutex_pool_assert.svh]
// Assertion macros shared by the mailbox, semaphore and mutex pool.
`ifndef MAILBOX_SEMAPHORE_MUTEX_POOL_ASSERT_SVH
`define MAILBOX_SEMAPHORE_MUTEX_POOL_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MSMP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msmp assertion failed");
`define MSMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msmp assertion failed");
`else
`define MSMP_ASSERT_NOW(label, ante, cons)
`define MSMP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[sv/msmp_pkg.sv]
// Types, codes and helper functions of the mailbox, semaphore and mutex pool.
`default_nettype none

package msmp_pkg;

    localparam logic [2:0] OP_PUT       = 3'd0;
    localparam logic [2:0] OP_GET       = 3'd1;
    localparam logic [2:0] OP_SEM_INIT  = 3'd2;
    localparam logic [2:0] OP_SEM_P     = 3'd3;
    localparam logic [2:0] OP_SEM_V     = 3'd4;
    localparam logic [2:0] OP_MTX_WAIT  = 3'd5;
    localparam logic [2:0] OP_MTX_REL   = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;

    localparam int DATA_W = 32;
    localparam int FLAG_W = 16;

    typedef struct packed {
        logic capture;
        logic execute;
    } msmp_cmd_t;

    function automatic logic [FLAG_W-1:0] clamp_count(input logic [DATA_W-1:0] raw);
        logic [FLAG_W-1:0] res;
        if (raw[DATA_W-1])
        begin
            res = '0;
        end
        else if (|raw[DATA_W-2:FLAG_W])
        begin
            res = '1;
        end
        else
        begin
            res = raw[FLAG_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/msmp_if.sv]
// Request and response channel interfaces of the mailbox, semaphore and mutex pool.
`default_nettype none

interface msmp_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic [7:0]         slot;
    logic signed [31:0] value;
    logic [31:0]        requester_id;

    modport source (output valid, output opcode, output slot, output value,
                    output requester_id, input ready);
    modport sink (input valid, input opcode, input slot, input value,
                  input requester_id, output ready);
endinterface

interface msmp_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] read_data;

    modport source (output valid, output status, output read_data, input ready);
    modport sink (input valid, input status, input read_data, output ready);
endinterface

`default_nettype wire

[sv/msmp_ctrl.sv]
// Controller state machine that sequences entry read, update and result handoff.
`default_nettype none

module msmp_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output msmp_pkg::msmp_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        in_ready    = (state_reg == S_IDLE);
        cmd.capture = in_valid && (state_reg == S_IDLE);
        cmd.execute = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.execute)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[sv/msmp_dp.sv]
// Datapath with the entry pool memory, range checks, operation logic and result register.
`default_nettype none

module msmp_dp #(
    parameter int POOL_DEPTH  = 32,
    parameter int SEM_FIRST   = 16,
    parameter int SEM_LAST    = 23,
    parameter int MUTEX_FIRST = 24,
    parameter int MUTEX_LAST  = 31
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire msmp_pkg::msmp_cmd_t cmd,
    input  wire logic [2:0]          opcode,
    input  wire logic [7:0]          slot,
    input  wire logic signed [31:0]  value,
    input  wire logic [31:0]         requester_id,
    output logic [1:0]               status,
    output logic signed [31:0]       read_data
);

    localparam int IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int DATA_W = msmp_pkg::DATA_W;
    localparam int FLAG_W = msmp_pkg::FLAG_W;
    localparam int WORD_W = DATA_W + FLAG_W;

    logic [WORD_W-1:0]     mem [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] valid_reg;

    logic [8:0]        slot_ext;
    logic [8:0]        sem_sum;
    logic [8:0]        mtx_sum;
    logic [8:0]        addr;
    logic              addr_ok;
    logic [IDX_W-1:0]  in_idx;

    logic [2:0]        op_reg;
    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] who_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              ok_reg;
    logic [WORD_W-1:0] rd_word_reg;
    logic              rd_valid_reg;

    logic [DATA_W-1:0] cur_data;
    logic [FLAG_W-1:0] cur_flag;
    logic              wr_en;
    logic [DATA_W-1:0] wr_data;
    logic [FLAG_W-1:0] wr_flag;
    logic [1:0]        st;
    logic [DATA_W-1:0] rd;

    logic [1:0]        status_reg;
    logic [DATA_W-1:0] read_data_reg;

    always_comb
    begin
        slot_ext = {1'b0, slot};
        sem_sum  = slot_ext + 9'(SEM_FIRST);
        mtx_sum  = slot_ext + 9'(MUTEX_FIRST);
        addr     = slot_ext;
        addr_ok  = 1'b0;
        if (opcode inside {msmp_pkg::OP_PUT, msmp_pkg::OP_GET})
        begin
            addr    = slot_ext;
            addr_ok = slot_ext < 9'(POOL_DEPTH);
        end
        else if (opcode inside {msmp_pkg::OP_SEM_INIT, msmp_pkg::OP_SEM_P,
                                msmp_pkg::OP_SEM_V})
        begin
            addr    = sem_sum;
            addr_ok = (sem_sum <= 9'(SEM_LAST)) && (sem_sum < 9'(POOL_DEPTH));
        end
        else if (opcode inside {msmp_pkg::OP_MTX_WAIT, msmp_pkg::OP_MTX_REL})
        begin
            addr    = mtx_sum;
            addr_ok = (mtx_sum <= 9'(MUTEX_LAST)) && (mtx_sum < 9'(POOL_DEPTH));
        end
        in_idx = addr[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= opcode;
            val_reg      <= value;
            who_reg      <= requester_id;
            idx_reg      <= in_idx;
            ok_reg       <= addr_ok;
            rd_word_reg  <= mem[in_idx];
            rd_valid_reg <= valid_reg[in_idx];
        end
        if (cmd.execute && wr_en)
        begin
            mem[idx_reg] <= {wr_data, wr_flag};
        end
        if (cmd.execute)
        begin
            status_reg    <= st;
            read_data_reg <= rd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.execute && wr_en)
        begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    always_comb
    begin
        cur_data = rd_valid_reg ? rd_word_reg[WORD_W-1:FLAG_W] : '0;
        cur_flag = rd_valid_reg ? rd_word_reg[FLAG_W-1:0] : '0;
        wr_en    = 1'b0;
        wr_data  = cur_data;
        wr_flag  = cur_flag;
        st       = msmp_pkg::ST_RANGE;
        rd       = '0;
        if (ok_reg)
        begin
            case (op_reg)
                msmp_pkg::OP_PUT:
                begin
                    wr_en   = 1'b1;
                    wr_data = val_reg;
                    wr_flag = FLAG_W'(1);
                    st      = msmp_pkg::ST_OK;
                end
                msmp_pkg::OP_GET:
                begin
                    if (cur_flag == '0)
                    begin
                        st = msmp_pkg::ST_BUSY;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_data = '0;
                        wr_flag = '0;
                        rd      = cur_data;
                        st      = msmp_pkg::ST_OK;
                    end
                end
                msmp_pkg::OP_SEM_INIT:
                begin
                    wr_en   = 1'b1;
                    wr_flag = msmp_pkg::clamp_count(val_reg);
                    st      = msmp_pkg::ST_OK;
                end
                msmp_pkg::OP_SEM_P:
                begin
                    if (cur_flag == '0)
                    begin
                        st = msmp_pkg::ST_BUSY;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_flag = cur_flag - FLAG_W'(1);
                        st      = msmp_pkg::ST_OK;
                    end
                end
                msmp_pkg::OP_SEM_V:
                begin
                    wr_en = 1'b1;
                    if (cur_flag != '1)
                    begin
                        wr_flag = cur_flag + FLAG_W'(1);
                    end
                    st = msmp_pkg::ST_OK;
                end
                msmp_pkg::OP_MTX_WAIT:
                begin
                    if (cur_flag == '0)
                    begin
                        wr_en   = 1'b1;
                        wr_flag = FLAG_W'(1);
                        wr_data = who_reg;
                        st      = msmp_pkg::ST_OK;
                    end
                    else
                    begin
                        st = msmp_pkg::ST_BUSY;
                    end
                end
                msmp_pkg::OP_MTX_REL:
                begin
                    if (cur_data != who_reg)
                    begin
                        st = msmp_pkg::ST_BUSY;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_flag = '0;
                        wr_data = '0;
                        st      = msmp_pkg::ST_OK;
                    end
                end
                default:
                begin
                    st = msmp_pkg::ST_RANGE;
                end
            endcase
        end
    end

    assign status    = status_reg;
    assign read_data = read_data_reg;

endmodule

`default_nettype wire

[sv/mailbox_semaphore_mutex_pool.sv]
// For each request transaction the addressed entry is first read from the pool memory into a
// register; then the entry is updated and the result is loaded into the response register.
// The response register lets the next request be accepted while a result is still waiting;
// the update step holds only while that register is full and not being taken. Entries are
// zero after reset through one valid flag per entry, so there is no clearing pass and
// requests are accepted right after reset.
`default_nettype none

`include "mailbox_semaphore_mutex_pool_assert.svh"

module mailbox_semaphore_mutex_pool #(
    parameter int POOL_DEPTH  = 32,
    parameter int SEM_FIRST   = 16,
    parameter int SEM_LAST    = 23,
    parameter int MUTEX_FIRST = 24,
    parameter int MUTEX_LAST  = 31
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    msmp_req_if.sink    req,
    msmp_rsp_if.source  rsp
);

    msmp_pkg::msmp_cmd_t cmd;

    msmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    msmp_dp #(
        .POOL_DEPTH  (POOL_DEPTH),
        .SEM_FIRST   (SEM_FIRST),
        .SEM_LAST    (SEM_LAST),
        .MUTEX_FIRST (MUTEX_FIRST),
        .MUTEX_LAST  (MUTEX_LAST)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .opcode       (req.opcode),
        .slot         (req.slot),
        .value        (req.value),
        .requester_id (req.requester_id),
        .status       (rsp.status),
        .read_data    (rsp.read_data)
    );

    `MSMP_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready)
    `MSMP_ASSERT_NOW(a_exec_room, cmd.execute, !rsp.valid || rsp.ready)
    `MSMP_ASSERT_NEXT(a_exec_result, cmd.execute, rsp.valid)
    `MSMP_ASSERT_NOW(a_data_only_ok, rsp.valid && (rsp.read_data != 0), rsp.status == msmp_pkg::ST_OK)

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the mailbox, semaphore and mutex pool.
module testbench;

    localparam int DEPTH = 32;
    localparam int SEM_BASE = 16;
    localparam int SEM_TOP = 23;
    localparam int MTX_BASE = 24;
    localparam int MTX_TOP = 31;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int PHASE_ITEMS = 550;

    logic clk;
    logic rst_n;
    int src_idle;
    int snk_idle;
    logic [31:0] caller_ids [4];

    msmp_req_if req_ch ();
    msmp_rsp_if rsp_ch ();

    mailbox_semaphore_mutex_pool #(
        .POOL_DEPTH (DEPTH),
        .SEM_FIRST  (SEM_BASE),
        .SEM_LAST   (SEM_TOP),
        .MUTEX_FIRST(MTX_BASE),
        .MUTEX_LAST (MTX_TOP)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    class pool_checker;
        logic [31:0] words [DEPTH];
        logic [15:0] counts [DEPTH];
        logic [1:0] expected_status [$];
        logic [31:0] expected_data [$];
        int mismatches;

        function new();
            foreach (words[i])
            begin
                words[i] = '0;
                counts[i] = '0;
            end
            mismatches = 0;
        endfunction

        function int region_entry(logic [7:0] slot, int base, int top);
            int idx;
            idx = int'(slot) + base;
            if (idx > top || idx >= DEPTH)
            begin
                return -1;
            end
            return idx;
        endfunction

        function void note_request(logic [2:0] op, logic [7:0] slot, logic [31:0] val,
                                   logic [31:0] who);
            logic [1:0] st;
            logic [31:0] rd;
            int idx;
            st = msmp_pkg::ST_RANGE;
            rd = '0;
            case (op)
                msmp_pkg::OP_PUT:
                begin
                    if (slot < DEPTH)
                    begin
                        words[slot] = val;
                        counts[slot] = 16'd1;
                        st = msmp_pkg::ST_OK;
                    end
                end
                msmp_pkg::OP_GET:
                begin
                    if (slot < DEPTH)
                    begin
                        if (counts[slot] == 16'd0)
                        begin
                            st = msmp_pkg::ST_BUSY;
                        end
                        else
                        begin
                            rd = words[slot];
                            words[slot] = '0;
                            counts[slot] = '0;
                            st = msmp_pkg::ST_OK;
                        end
                    end
                end
                msmp_pkg::OP_SEM_INIT, msmp_pkg::OP_SEM_P, msmp_pkg::OP_SEM_V:
                begin
                    idx = region_entry(slot, SEM_BASE, SEM_TOP);
                    if (idx >= 0)
                    begin
                        st = msmp_pkg::ST_OK;
                        if (op == msmp_pkg::OP_SEM_INIT)
                        begin
                            if (val[31])
                                counts[idx] = '0;
                            else if (val > 32'h0000_FFFF)
                                counts[idx] = 16'hFFFF;
                            else
                                counts[idx] = val[15:0];
                        end
                        else if (op == msmp_pkg::OP_SEM_P)
                        begin
                            if (counts[idx] == 16'd0)
                                st = msmp_pkg::ST_BUSY;
                            else
                                counts[idx] = counts[idx] - 16'd1;
                        end
                        else if (counts[idx] != 16'hFFFF)
                        begin
                            counts[idx] = counts[idx] + 16'd1;
                        end
                    end
                end
                msmp_pkg::OP_MTX_WAIT, msmp_pkg::OP_MTX_REL:
                begin
                    idx = region_entry(slot, MTX_BASE, MTX_TOP);
                    if (idx >= 0)
                    begin
                        st = msmp_pkg::ST_BUSY;
                        if (op == msmp_pkg::OP_MTX_WAIT && counts[idx] == 16'd0)
                        begin
                            counts[idx] = 16'd1;
                            words[idx] = who;
                            st = msmp_pkg::ST_OK;
                        end
                        else if (op == msmp_pkg::OP_MTX_REL && words[idx] == who)
                        begin
                            counts[idx] = '0;
                            words[idx] = '0;
                            st = msmp_pkg::ST_OK;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            expected_status.push_back(st);
            expected_data.push_back(rd);
        endfunction

        function void check_response(logic [1:0] status, logic [31:0] data);
            logic [1:0] st;
            logic [31:0] rd;
            if (expected_status.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected response transaction, status %0d read_data %h",
                         $time, status, data);
                return;
            end
            st = expected_status.pop_front();
            rd = expected_data.pop_front();
            if (status !== st)
            begin
                mismatches++;
                $display("%0t: status mismatch, expected %0d actual %0d", $time, st, status);
            end
            if (data !== rd)
            begin
                mismatches++;
                $display("%0t: read_data mismatch, expected %h actual %h", $time, rd, data);
            end
        endfunction

        function int pending();
            return expected_status.size();
        endfunction
    endclass

    pool_checker sb = new();

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.opcode, req_ch.slot, req_ch.value, req_ch.requester_id);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.status, rsp_ch.read_data);
        end
    end

    task automatic send_op(input logic [2:0] op, input logic [7:0] slot,
                           input logic [31:0] val, input logic [31:0] who);
        while ($urandom_range(0, 99) < src_idle)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.opcode <= op;
        req_ch.slot <= slot;
        req_ch.value <= val;
        req_ch.requester_id <= who;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_slot(input logic [2:0] op);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'($urandom_range(0, 255));
        if (op == msmp_pkg::OP_PUT || op == msmp_pkg::OP_GET)
            return (r == 1) ? 8'($urandom_range(28, 40)) : 8'($urandom_range(0, DEPTH - 1));
        return 8'($urandom_range(0, 8));
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 32'($urandom_range(0, 6));
        if (r == 4)
            return 32'($urandom_range(65532, 65537));
        if (r == 5)
            return {1'b1, 31'($urandom)};
        return 32'($urandom);
    endfunction

    function automatic logic [31:0] pick_id();
        if ($urandom_range(0, 9) == 0)
            return 32'($urandom);
        return caller_ids[$urandom_range(0, 3)];
    endfunction

    task automatic random_traffic(input int count);
        int n;
        int kind;
        int k;
        logic [7:0] s;
        logic [31:0] id;
        logic [2:0] op;
        n = 0;
        while (n < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 2)
            begin
                s = pick_slot(msmp_pkg::OP_PUT);
                send_op(msmp_pkg::OP_PUT, s, pick_value(), pick_id());
                send_op(msmp_pkg::OP_GET, s, pick_value(), pick_id());
                n += 2;
            end
            else if (kind < 4)
            begin
                s = pick_slot(msmp_pkg::OP_MTX_WAIT);
                id = pick_id();
                send_op(msmp_pkg::OP_MTX_WAIT, s, pick_value(), id);
                if ($urandom_range(0, 1))
                begin
                    send_op(msmp_pkg::OP_MTX_WAIT, s, pick_value(), pick_id());
                    n++;
                end
                send_op(msmp_pkg::OP_MTX_REL, s, pick_value(), id);
                n += 2;
            end
            else if (kind == 4)
            begin
                s = pick_slot(msmp_pkg::OP_SEM_INIT);
                send_op(msmp_pkg::OP_SEM_INIT, s, pick_value(), pick_id());
                for (k = 0; k < 4; k++)
                    send_op($urandom_range(0, 1) ? msmp_pkg::OP_SEM_P : msmp_pkg::OP_SEM_V,
                            s, pick_value(), pick_id());
                n += 5;
            end
            else
            begin
                op = 3'($urandom_range(0, 7));
                send_op(op, pick_slot(op), pick_value(), pick_id());
                n++;
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        src_idle = 18;
        snk_idle = 58;
        req_ch.valid = 1'b0;
        req_ch.opcode = msmp_pkg::OP_PUT;
        req_ch.slot = '0;
        req_ch.value = '0;
        req_ch.requester_id = '0;
        rsp_ch.ready = 1'b0;
        caller_ids[0] = '0;
        caller_ids[1] = 32'hFFFF_FFFF;
        caller_ids[2] = 32'($urandom);
        caller_ids[3] = 32'($urandom);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(msmp_pkg::OP_GET, 8'd0, 32'd0, 32'd0);
        send_op(msmp_pkg::OP_PUT, 8'd0, 32'h7FFF_FFFF, 32'd0);
        send_op(msmp_pkg::OP_PUT, 8'd31, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(msmp_pkg::OP_GET, 8'd0, 32'd0, 32'd0);
        send_op(msmp_pkg::OP_GET, 8'd31, 32'd0, 32'd0);
        send_op(msmp_pkg::OP_PUT, 8'd32, 32'h1234_5678, 32'd0);
        send_op(msmp_pkg::OP_GET, 8'd255, 32'd0, 32'd0);
        send_op(msmp_pkg::OP_SEM_INIT, 8'd0, 32'hFFFF_FFFF, 32'd0);
        send_op(msmp_pkg::OP_SEM_P, 8'd0, 32'd0, 32'd0);
        send_op(msmp_pkg::OP_SEM_INIT, 8'd7, 32'h0001_0000, 32'd0);
        send_op(msmp_pkg::OP_SEM_V, 8'd7, 32'd0, 32'd0);
        send_op(msmp_pkg::OP_SEM_P, 8'd7, 32'd0, 32'd0);
        send_op(msmp_pkg::OP_SEM_INIT, 8'd8, 32'd3, 32'd0);
        send_op(msmp_pkg::OP_SEM_V, 8'd255, 32'd0, 32'd0);
        send_op(msmp_pkg::OP_SEM_V, 8'd0, 32'd0, 32'd0);
        send_op(msmp_pkg::OP_MTX_WAIT, 8'd0, 32'd0, 32'hFFFF_FFFF);
        send_op(msmp_pkg::OP_MTX_WAIT, 8'd0, 32'd0, 32'd1);
        send_op(msmp_pkg::OP_MTX_REL, 8'd0, 32'd0, 32'd1);
        send_op(msmp_pkg::OP_MTX_REL, 8'd0, 32'd0, 32'hFFFF_FFFF);
        send_op(msmp_pkg::OP_MTX_REL, 8'd1, 32'd0, 32'd0);
        send_op(msmp_pkg::OP_MTX_WAIT, 8'd7, 32'd0, 32'd0);
        send_op(msmp_pkg::OP_MTX_REL, 8'd8, 32'd0, 32'd0);
        send_op(msmp_pkg::OP_GET, 8'd16, 32'd0, 32'd0);
        send_op(OP_UNUSED, 8'd0, 32'd0, 32'd0);

        random_traffic(PHASE_ITEMS);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        src_idle = 58;
        snk_idle = 18;
        random_traffic(PHASE_ITEMS);
        src_idle = 0;
        snk_idle = 0;
        random_traffic(PHASE_ITEMS);
        req_ch.valid <= 1'b0;
        @(posedge clk);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule

[files.f]
+incdir+sv
sv/msmp_pkg.sv
sv/msmp_if.sv
sv/msmp_ctrl.sv
sv/msmp_dp.sv
sv/mailbox_semaphore_mutex_pool.sv
dv/testbench.sv
